FILE: src/first_fit_free_list_allocator_assert.svh
// Assertion macros shared by the allocator modules.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Check prop at every rising clock edge outside reset.
`define FFA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check cons in the cycle after ante.
`define FFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ffa_pkg.sv
// Types, constants and codes of the first-fit free-list allocator.
package ffa_pkg;

  localparam int unsigned MAX_REGIONS = 512;
  localparam int unsigned ADDR_W      = $clog2(MAX_REGIONS);
  localparam int unsigned CNT_W       = $clog2(MAX_REGIONS + 1);

  localparam logic [31:0] HDR_BYTES         = 32'd4;
  localparam logic [31:0] HEAP_BASE_RESET   = 32'hC050_0000;
  localparam logic [31:0] HEAP_LENGTH_RESET = 32'h0040_0000;

  localparam logic CFG_HEAP_BASE   = 1'b0;
  localparam logic CFG_HEAP_LENGTH = 1'b1;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_OVERLAP = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] alloc_size;
    logic [31:0] free_address;
    logic [31:0] free_length;
  } req_t;

  typedef struct packed {
    logic [31:0] payload_address;
    logic [31:0] block_length;
    logic [2:0]  status;
    logic [9:0]  regions_in_use;
  } rsp_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
  } region_t;

  typedef enum logic [1:0] {RD_IDX, RD_NEXT, RD_PREV} rd_sel_e;
  typedef enum logic [1:0] {WR_SHRINK, WR_MOVE, WR_INSERT, WR_INIT} wr_sel_e;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INIT, CNT_INC, CNT_DEC} cnt_op_e;
  typedef enum logic [2:0] {IDX_HOLD, IDX_CLR, IDX_INC, IDX_DEC, IDX_CNT} idx_op_e;

  typedef struct packed {
    logic       ld_req;
    idx_op_e    idx_op;
    logic       pos_ld;
    logic       prev_clr;
    logic       prev_ld;
    logic       hit_ld;
    logic       rd_en;
    rd_sel_e    rd_sel;
    logic       wr_en;
    wr_sel_e    wr_sel;
    cnt_op_e    cnt_op;
    logic       res_ld;
    logic       res_hit;
    logic [2:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       cnt_zero;
    logic       cnt_full;
    logic       idx_at_cnt;
    logic       idx_at_pos;
    logic       size_ovf;
    logic       free_null;
    logic       free_past_top;
    logic       fit;
    logic       exact;
    logic       le;
    logic       prev_ovl;
    logic       next_ovl;
  } sts_t;

endpackage

FILE: src/ffa_dp.sv
// Datapath: region table memory, request registers, compares and result register.
`include "first_fit_free_list_allocator_assert.svh"

module ffa_dp import ffa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  req_t        in_req_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output rsp_t        out_rsp_o
);

  region_t mem [MAX_REGIONS];

  logic [31:0]      base_q, hlen_q;
  logic [CNT_W-1:0] cnt_q, idx_q, pos_q;
  logic             prev_vld_q;
  region_t          prev_q, rdata_q;
  logic [1:0]       req_type_q;
  logic [31:0]      need_q, fstart_q, flen_q, hit_addr_q;
  logic             ovf_q, null_q;
  logic [32:0]      fend_q;
  rsp_t             rsp_q;

  logic [32:0]       need_c, fend_c, prev_end_c;
  logic [31:0]       fstart_c;
  logic [CNT_W-1:0]  rd_idx;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  region_t           wr_data;

  assign need_c     = {1'b0, in_req_i.alloc_size} + {1'b0, HDR_BYTES};
  assign fstart_c   = in_req_i.free_address - HDR_BYTES;
  assign fend_c     = {1'b0, fstart_c} + {1'b0, in_req_i.free_length};
  assign prev_end_c = {1'b0, prev_q.start} + {1'b0, prev_q.size};

  always_comb begin
    case (cmd_i.rd_sel)
      RD_NEXT: rd_idx = idx_q + CNT_W'(1);
      RD_PREV: rd_idx = idx_q - CNT_W'(1);
      default: rd_idx = idx_q;
    endcase
    rd_addr = rd_idx[ADDR_W-1:0];
    wr_addr = (cmd_i.wr_sel == WR_INIT) ? '0 : idx_q[ADDR_W-1:0];
    case (cmd_i.wr_sel)
      WR_SHRINK: wr_data = '{start: rdata_q.start + need_q, size: rdata_q.size - need_q};
      WR_MOVE:   wr_data = rdata_q;
      WR_INSERT: wr_data = '{start: fstart_q, size: flen_q};
      default:   wr_data = '{start: base_q, size: hlen_q};
    endcase
  end

  always_comb begin
    sts_o.req_type      = req_type_q;
    sts_o.cnt_zero      = (cnt_q == '0);
    sts_o.cnt_full      = (cnt_q >= CNT_W'(MAX_REGIONS));
    sts_o.idx_at_cnt    = (idx_q == cnt_q);
    sts_o.idx_at_pos    = (idx_q == pos_q);
    sts_o.size_ovf      = ovf_q;
    sts_o.free_null     = null_q;
    sts_o.free_past_top = fend_q[32] && (fend_q[31:0] != '0);
    sts_o.fit           = (rdata_q.size >= need_q);
    sts_o.exact         = (rdata_q.size == need_q);
    sts_o.le            = (rdata_q.start <= fstart_q);
    sts_o.prev_ovl      = prev_vld_q &&
                          ((prev_q.start == fstart_q) || (prev_end_c > {1'b0, fstart_q}));
    sts_o.next_ovl      = ({1'b0, rdata_q.start} < fend_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= HEAP_BASE_RESET;
      hlen_q     <= HEAP_LENGTH_RESET;
      cnt_q      <= CNT_W'(1);
      idx_q      <= '0;
      pos_q      <= '0;
      prev_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_HEAP_BASE) base_q <= cfg_wdata_i;
        if (cfg_index_i == CFG_HEAP_LENGTH) hlen_q <= cfg_wdata_i;
      end
      case (cmd_i.cnt_op)
        CNT_INIT: cnt_q <= CNT_W'(1);
        CNT_INC:  cnt_q <= cnt_q + CNT_W'(1);
        CNT_DEC:  cnt_q <= cnt_q - CNT_W'(1);
        default:  cnt_q <= cnt_q;
      endcase
      case (cmd_i.idx_op)
        IDX_CLR: idx_q <= '0;
        IDX_INC: idx_q <= idx_q + CNT_W'(1);
        IDX_DEC: idx_q <= idx_q - CNT_W'(1);
        IDX_CNT: idx_q <= cnt_q;
        default: idx_q <= idx_q;
      endcase
      if (cmd_i.pos_ld) pos_q <= idx_q;
      if (cmd_i.prev_clr) prev_vld_q <= 1'b0;
      else if (cmd_i.prev_ld) prev_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_req) begin
      req_type_q <= in_req_i.req_type;
      need_q     <= need_c[31:0];
      ovf_q      <= need_c[32];
      fstart_q   <= fstart_c;
      flen_q     <= in_req_i.free_length;
      fend_q     <= fend_c;
      null_q     <= (in_req_i.free_address == '0) || (in_req_i.free_length == '0);
    end
    if (cmd_i.prev_ld) prev_q <= rdata_q;
    if (cmd_i.hit_ld) hit_addr_q <= rdata_q.start + HDR_BYTES;
    if (cmd_i.rd_en) rdata_q <= mem[rd_addr];
    if (cmd_i.wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.res_ld) begin
      rsp_q.payload_address <= cmd_i.res_hit ? hit_addr_q : '0;
      rsp_q.block_length    <= cmd_i.res_hit ? need_q : '0;
      rsp_q.status          <= cmd_i.res_status;
      rsp_q.regions_in_use  <= 10'(cnt_q);
    end
  end

  assign out_rsp_o = rsp_q;

  `FFA_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CNT_W'(MAX_REGIONS), "region count above table depth")
  `FFA_ASSERT(a_wr_in_table, clk_i, rst_ni, !cmd_i.wr_en || (cmd_i.wr_sel == WR_INIT) || (idx_q <= cnt_q), "table write beyond held regions")
  `FFA_ASSERT(a_dec_nonzero, clk_i, rst_ni, (cmd_i.cnt_op != CNT_DEC) || (cnt_q != '0), "region count underflow")

endmodule

FILE: src/ffa_ctrl.sv
// Controller: sequences table scans, shifts and result transactions.
`include "first_fit_free_list_allocator_assert.svh"

module ffa_ctrl import ffa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_BOOT, S_IDLE, S_DEC, S_A_RD, S_A_CHK, S_A_SRD, S_A_SWR,
    S_F_RD, S_F_CHK, S_F_SRD, S_F_SWR, S_FIN
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] st_q, st_d;
  logic       hit_q, hit_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o            = '0;
    cmd_o.idx_op     = IDX_HOLD;
    cmd_o.rd_sel     = RD_IDX;
    cmd_o.wr_sel     = WR_MOVE;
    cmd_o.cnt_op     = CNT_HOLD;
    cmd_o.res_status = st_q;
    cmd_o.res_hit    = hit_q;
    state_d          = state_q;
    st_d             = st_q;
    hit_d            = hit_q;
    out_valid_d      = out_valid_q && out_stall_i;
    case (state_q)
      S_BOOT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_INIT;
        cmd_o.cnt_op = CNT_INIT;
        state_d      = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_req = 1'b1;
          hit_d        = 1'b0;
          st_d         = ST_OK;
          state_d      = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_FIN;
        case (sts_i.req_type)
          REQ_ALLOC: begin
            if (sts_i.cnt_zero) st_d = ST_EMPTY;
            else if (sts_i.size_ovf) st_d = ST_NOFIT;
            else begin
              cmd_o.idx_op = IDX_CLR;
              state_d      = S_A_RD;
            end
          end
          REQ_FREE: begin
            if (sts_i.free_null) st_d = ST_OK;
            else if (sts_i.free_past_top) st_d = ST_NOFIT;
            else begin
              cmd_o.idx_op   = IDX_CLR;
              cmd_o.prev_clr = 1'b1;
              state_d        = S_F_RD;
            end
          end
          REQ_INIT: begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WR_INIT;
            cmd_o.cnt_op = CNT_INIT;
          end
          default: st_d = ST_OK;
        endcase
      end
      S_A_RD: begin
        if (sts_i.idx_at_cnt) begin
          st_d    = ST_NOFIT;
          state_d = S_FIN;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (sts_i.fit) begin
          cmd_o.hit_ld = 1'b1;
          hit_d        = 1'b1;
          if (sts_i.exact) begin
            cmd_o.cnt_op = CNT_DEC;
            state_d      = S_A_SRD;
          end else begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WR_SHRINK;
            state_d      = S_FIN;
          end
        end else begin
          cmd_o.idx_op = IDX_INC;
          state_d      = S_A_RD;
        end
      end
      S_A_SRD: begin
        if (sts_i.idx_at_cnt) state_d = S_FIN;
        else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_NEXT;
          state_d      = S_A_SWR;
        end
      end
      S_A_SWR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.idx_op = IDX_INC;
        state_d      = S_A_SRD;
      end
      S_F_RD: begin
        if (sts_i.idx_at_cnt) begin
          state_d = S_FIN;
          if (sts_i.prev_ovl) st_d = ST_OVERLAP;
          else if (sts_i.cnt_full) st_d = ST_FULL;
          else begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WR_INSERT;
            cmd_o.cnt_op = CNT_INC;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (sts_i.le) begin
          cmd_o.prev_ld = 1'b1;
          cmd_o.idx_op  = IDX_INC;
          state_d       = S_F_RD;
        end else if (sts_i.prev_ovl || sts_i.next_ovl) begin
          st_d    = ST_OVERLAP;
          state_d = S_FIN;
        end else if (sts_i.cnt_full) begin
          st_d    = ST_FULL;
          state_d = S_FIN;
        end else begin
          cmd_o.pos_ld = 1'b1;
          cmd_o.idx_op = IDX_CNT;
          state_d      = S_F_SRD;
        end
      end
      S_F_SRD: begin
        if (sts_i.idx_at_pos) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_INSERT;
          cmd_o.cnt_op = CNT_INC;
          state_d      = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PREV;
          state_d      = S_F_SWR;
        end
      end
      S_F_SWR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.idx_op = IDX_DEC;
        state_d      = S_F_SRD;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.res_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_BOOT;
      st_q        <= ST_OK;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `FFA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == S_DEC, "accepted transaction not decoded")
  `FFA_ASSERT(a_hit_ok, clk_i, rst_ni, !(cmd_o.res_ld && hit_q) || (st_q == ST_OK), "allocation result with error status")
  `FFA_ASSERT(a_rise_from_fin, clk_i, rst_ni, !$rose(out_valid_q) || $past(state_q == S_FIN), "result raised outside finish")

endmodule

FILE: src/first_fit_free_list_allocator.sv
// Top level of the first-fit free-list allocator.
// The block keeps up to MAX_REGIONS free regions in a single-port table memory
// and serves one request at a time. After reset it loads the heap region into
// entry 0 before it takes a request. Init and requests that end early go from
// decode straight to the finish state. An allocate reads the table entries in
// order until a region fits; when it uses a region up exactly, the entries
// above move down one by one. A free scans the same way to its insert point
// and then moves the entries above up one by one. A result waits in an output
// register while the next request is taken.
module first_fit_free_list_allocator import ffa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_rsp_o
);

  cmd_t cmd;
  sts_t sts;

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the first-fit free-list allocator.
`timescale 1ns / 1ps

module tb;
  import ffa_pkg::*;

  class region_scoreboard;
    logic [31:0] base_reg;
    logic [31:0] length_reg;
    logic [31:0] reg_start [MAX_REGIONS];
    logic [31:0] reg_size [MAX_REGIONS];
    int unsigned held;
    rsp_t        pending [$];
    int          mismatches;
    int          results;
    int          status_seen [8];

    function void reset_state();
      base_reg   = HEAP_BASE_RESET;
      length_reg = HEAP_LENGTH_RESET;
      reload();
      pending.delete();
      mismatches = 0;
      results = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void reload();
      foreach (reg_start[i]) begin
        reg_start[i] = '0;
        reg_size[i] = '0;
      end
      reg_start[0] = base_reg;
      reg_size[0] = length_reg;
      held = 1;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == CFG_HEAP_BASE) base_reg = value;
      else length_reg = value;
    endfunction

    function logic [2:0] take(logic [31:0] size, output logic [31:0] addr,
                              output logic [31:0] len);
      logic [32:0] need;
      logic [31:0] first;
      need = {1'b0, size} + 33'd4;
      addr = '0;
      len = '0;
      if (held == 0) return ST_EMPTY;
      if (need[32]) return ST_NOFIT;
      for (int i = 0; i < held; i++) begin
        if ({1'b0, reg_size[i]} >= need) begin
          first = reg_start[i];
          reg_start[i] = first + need[31:0];
          reg_size[i] = reg_size[i] - need[31:0];
          if (reg_size[i] == 0) begin
            held--;
            for (int j = i; j < held; j++) begin
              reg_start[j] = reg_start[j+1];
              reg_size[j] = reg_size[j+1];
            end
          end
          addr = first + HDR_BYTES;
          len = need[31:0];
          return ST_OK;
        end
      end
      return ST_NOFIT;
    endfunction

    function logic [2:0] give_back(logic [31:0] addr, logic [31:0] len);
      logic [31:0] lo;
      logic [32:0] hi;
      int          p;
      if (addr == 0 || len == 0) return ST_OK;
      lo = addr - HDR_BYTES;
      hi = {1'b0, lo} + {1'b0, len};
      if (hi > 33'h1_0000_0000) return ST_NOFIT;
      p = 0;
      while (p < held && reg_start[p] <= lo) p++;
      if (p > 0) begin
        if (reg_start[p-1] == lo ||
            {1'b0, reg_start[p-1]} + {1'b0, reg_size[p-1]} > {1'b0, lo})
          return ST_OVERLAP;
      end
      if (p < held && {1'b0, reg_start[p]} < hi) return ST_OVERLAP;
      if (held >= MAX_REGIONS) return ST_FULL;
      for (int j = held; j > p; j--) begin
        reg_start[j] = reg_start[j-1];
        reg_size[j] = reg_size[j-1];
      end
      reg_start[p] = lo;
      reg_size[p] = len;
      held++;
      return ST_OK;
    endfunction

    function rsp_t note_request(req_t r);
      rsp_t        e;
      logic [31:0] a;
      logic [31:0] l;
      e = '0;
      a = '0;
      l = '0;
      case (r.req_type)
        REQ_ALLOC: e.status = take(r.alloc_size, a, l);
        REQ_FREE:  e.status = give_back(r.free_address, r.free_length);
        REQ_INIT:  reload();
        default:   e.status = ST_OK;
      endcase
      if (e.status == ST_OK) begin
        e.payload_address = a;
        e.block_length = l;
      end
      e.regions_in_use = held[9:0];
      pending.push_back(e);
      return e;
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      results++;
      status_seen[got.status]++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", got);
        return;
      end
      e = pending.pop_front();
      if (got.payload_address !== e.payload_address || got.block_length !== e.block_length ||
          got.status !== e.status || got.regions_in_use !== e.regions_in_use) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: addr %h/%h len %h/%h status %0d/%0d regions %0d/%0d (exp/act)",
                   e.payload_address, got.payload_address, e.block_length, got.block_length,
                   e.status, got.status, e.regions_in_use, got.regions_in_use);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CFG_HEAP_BASE;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  req_t        in_req_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rsp_t        out_rsp_o;

  region_scoreboard sb = new();
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          sent = 0;
  rsp_t        last_exp;
  logic [31:0] live_addr [$];
  logic [31:0] live_len [$];

  first_fit_free_list_allocator uut (.*);

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_response(out_rsp_o);

  initial begin
    #160ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send(req_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i = r;
    do @(posedge clk_i); while (in_stall_o);
    last_exp = sb.note_request(r);
    sent++;
    if (r.req_type == REQ_ALLOC && last_exp.status == ST_OK) begin
      live_addr.push_back(last_exp.payload_address);
      live_len.push_back(last_exp.block_length);
    end
    if (r.req_type == REQ_INIT) begin
      live_addr.delete();
      live_len.delete();
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic req(logic [1:0] kind, logic [31:0] size, logic [31:0] addr,
                     logic [31:0] len);
    req_t r;
    r.req_type = kind;
    r.alloc_size = size;
    r.free_address = addr;
    r.free_length = len;
    send(r);
  endtask

  task automatic set_heap(logic [31:0] base, logic [31:0] len);
    drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = CFG_HEAP_BASE;
    cfg_wdata_i = base;
    @(negedge clk_i);
    cfg_index_i = CFG_HEAP_LENGTH;
    cfg_wdata_i = len;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.write_reg(CFG_HEAP_BASE, base);
    sb.write_reg(CFG_HEAP_LENGTH, len);
    req(REQ_INIT, '0, '0, '0);
  endtask

  task automatic random_items(int n);
    int roll;
    int k;
    req_t r;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        req(REQ_ALLOC, ($urandom_range(9) == 0) ? $urandom_range(0, 32'h1_0000)
                                                : $urandom_range(0, 300), '0, '0);
      end else if (roll < 82 && live_addr.size() != 0) begin
        k = $urandom_range(live_addr.size() - 1);
        req(REQ_FREE, $urandom, live_addr[k], live_len[k]);
        if ($urandom_range(9) != 0) begin
          live_addr.delete(k);
          live_len.delete(k);
        end
      end else if (roll < 86) begin
        req(REQ_INIT, $urandom, $urandom, $urandom);
      end else begin
        r.req_type = 2'($urandom);
        r.alloc_size = $urandom;
        r.free_address = $urandom;
        r.free_length = $urandom;
        send(r);
      end
    end
  endtask

  initial begin
    sb.reset_state();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    req(REQ_ALLOC, 32'd0, '0, '0);
    req(REQ_ALLOC, 32'hFFFF_FFFC, '0, '0);
    req(REQ_ALLOC, 32'hFFFF_FFFB, '0, '0);
    req(REQ_FREE, '0, 32'd0, 32'd8);
    req(REQ_FREE, '0, 32'h1234_0000, 32'd0);
    req(REQ_FREE, '0, 32'hFFFF_FFF0, 32'h100);
    req(REQ_FREE, '0, 32'hC050_0004, 32'd4);
    req(REQ_FREE, '0, 32'hC050_0004, 32'd4);
    req(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_heap(32'h1000, 32'h20);
    req(REQ_ALLOC, 32'h1C, '0, '0);
    req(REQ_ALLOC, 32'd0, '0, '0);
    req(REQ_FREE, '0, 32'h1008, 32'd8);
    req(REQ_FREE, '0, 32'h100C, 32'd8);
    set_heap(32'hFFFF_FFF0, 32'h40);
    req(REQ_ALLOC, 32'd12, '0, '0);
    req(REQ_ALLOC, 32'd0, '0, '0);
    set_heap(32'h0, 32'h0);
    req(REQ_ALLOC, 32'd0, '0, '0);
    set_heap(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    req(REQ_ALLOC, 32'hFFFF_FFFB, '0, '0);

    set_heap(32'h0, 32'h0);
    for (int k = 1; k < MAX_REGIONS; k++) begin
      if (k < 128) begin
        idle_pct = 0;
        stall_pct = 0;
      end else if (k < 256) begin
        idle_pct = 69;
        stall_pct = 0;
      end else if (k < 384) begin
        idle_pct = 0;
        stall_pct = 69;
      end else begin
        idle_pct = 30;
        stall_pct = 30;
      end
      req(REQ_FREE, '0, 32'h1000 * k + 4, 32'd16);
    end
    idle_pct = 0;
    stall_pct = 0;
    req(REQ_FREE, '0, 32'h0010_0084, 32'd16);
    req(REQ_FREE, '0, 32'h1004, 32'd16);
    req(REQ_ALLOC, 32'd0, '0, '0);

    set_heap(HEAP_BASE_RESET, HEAP_LENGTH_RESET);
    random_items(10);
    set_heap($urandom, 32'h1000);
    idle_pct = 69;
    random_items(5);
    drain();
    random_items(5);
    set_heap(32'hFFFF_F000, 32'h2000);
    idle_pct = 0;
    stall_pct = 69;
    random_items(10);
    set_heap($urandom, $urandom_range(32'h100, 32'h10_0000));
    idle_pct = 30;
    stall_pct = 30;
    random_items(10);

    drain();
    repeat (1100) @(posedge clk_i);
    $display("sent %0d requests, checked %0d results", sent, sb.results);
    $display("status ok %0d, nofit %0d, overlap %0d, full %0d, empty %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_NOFIT], sb.status_seen[ST_OVERLAP],
             sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY]);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
